[hw/rtl/facm_pkg.sv]
// Shared types and constants for the focus actuator motion model.
// Used by facm_step_unit and focus_actuator_motion_model_core; no dependencies.
`default_nettype none

package facm_pkg;

  localparam int POS_BITS_DEF    = 16;
  localparam logic [15:0] FULL_RATE_RESET = 16'd32768;

  // step = ((full_rate * |vel| * ms) >> RATE_FRAC) / 1000,
  // the divide done as a multiply by MS_RECIP and a shift by MS_RECIP_SH
  localparam int RATE_FRAC = 15;
  localparam int DVD_W     = 32;
  localparam int STEP_W    = 23;
  localparam logic [DVD_W-1:0] MS_RECIP = 32'd274877907;
  localparam int MS_RECIP_SH = 38;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_MOVE    = 2'd1,
    OP_STOP    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_CONT   = 2'd1,
    MODE_TARGET = 2'd2
  } mode_t;

  typedef struct packed {
    logic        start;
    logic [15:0] rate;
    logic [15:0] mag;
    logic [15:0] ms;
  } step_req_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] step;
  } step_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/focus_actuator_motion_model_core.sv]
// Focus actuator motion model, top level.
// Depends on facm_pkg and facm_step_unit.
//
// Use: one input beat on s_* carries a command and the elapsed milliseconds;
// the block integrates motion over that time, applies the command and returns
// one beat on m_* with the position and a moving flag. full_rate is written on
// the cfg_* channel, which is always ready; write it only while idle.
// When the actuator is idle, an accepted item goes straight to the command
// stage; else it passes through the step stage (three passes through the shared
// multiplier in the step unit, the last a reciprocal multiply for the divide by
// 1000), the advance stage and the command stage. s_tready is high only between
// items, so a new item is not accepted until the last one is through.
// The result sits in an output register; the next item is accepted while it
// waits. If the register is full and m_tready is low, a finished item holds in
// the command stage until the register frees, and no further item is accepted.
// Reset (rst, synchronous): position mid travel, idle, full_rate 32768,
// output empty.
`default_nettype none

module focus_actuator_motion_model_core import facm_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // elapsed_ms[15:0], distance[32:16], speed[48:33], zeros
  input  wire logic [1:0]  s_tuser,  // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata   // position[15:0], moving[16], zeros
);

  localparam int AW = ((POS_BITS > STEP_W) ? POS_BITS : STEP_W) + 2;
  localparam logic [POS_BITS-1:0] FULL = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] MID  = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_WAIT = 4'b0001,
    ST_STEP = 4'b0010,
    ST_ADV  = 4'b0100,
    ST_CMD  = 4'b1000
  } state_t;

  state_t               state;
  logic [15:0]          full_rate;
  logic [POS_BITS-1:0]  focus_pos;
  mode_t                mode;
  logic signed [16:0]   vel;
  logic [POS_BITS-1:0]  target;
  logic [1:0]           op_q;
  logic signed [16:0]   dist_q;
  logic signed [15:0]   spd_q;

  step_req_t req;
  step_rsp_t rsp;

  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [AW-1:0] v);
    if (v < 0) return '0;
    if (v > signed'(AW'(FULL))) return FULL;
    return v[POS_BITS-1:0];
  endfunction

  logic                accept;
  logic                load_out;
  logic signed [16:0]  mag17;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_WAIT);
  assign cfg_ready = 1'b1;
  assign load_out  = (state == ST_CMD) && (!m_tvalid || m_tready);
  assign mag17     = vel[16] ? -vel : vel;

  assign req.start = accept && (mode != MODE_IDLE);
  assign req.rate  = full_rate;
  assign req.mag   = mag17[15:0];
  assign req.ms    = s_tdata[15:0];

  facm_step_unit u_step (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // advance over the elapsed time
  logic signed [AW-1:0] pos_s, stp_s, sum_c, rem_c, absr_c, tstep_c;
  logic [POS_BITS-1:0]  adv_pos;
  logic                 adv_idle;

  always_comb begin
    pos_s    = signed'(AW'(focus_pos));
    stp_s    = signed'(AW'(rsp.step));
    rem_c    = signed'(AW'(target)) - pos_s;
    absr_c   = (rem_c < 0) ? -rem_c : rem_c;
    sum_c    = (vel < 0) ? pos_s - stp_s : pos_s + stp_s;
    tstep_c  = (rem_c > 0) ? pos_s + stp_s : pos_s - stp_s;
    adv_pos  = focus_pos;
    adv_idle = 1'b0;
    case (mode)
      MODE_CONT: begin
        adv_pos  = clamp_pos(sum_c);
        adv_idle = !((vel > 0 && adv_pos < FULL) || (vel < 0 && adv_pos != '0));
      end
      MODE_TARGET: begin
        if (absr_c <= stp_s) begin
          adv_pos  = target;
          adv_idle = 1'b1;
        end else begin
          adv_pos = tstep_c[POS_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // command, then a zero-length advance
  mode_t                mode_c;
  logic signed [16:0]   vel_c;
  logic [POS_BITS-1:0]  tgt_c;
  logic signed [16:0]   spd17;
  logic signed [16:0]   spd_mag;
  logic signed [AW-1:0] dist_s;

  always_comb begin
    spd17   = {spd_q[15], spd_q};
    spd_mag = spd17[16] ? -spd17 : spd17;
    dist_s  = signed'({{(AW-17){dist_q[16]}}, dist_q});
    mode_c  = mode;
    vel_c   = vel;
    tgt_c   = target;
    case (op_q)
      OP_MOVE: begin
        if (dist_q != 0) begin
          tgt_c  = clamp_pos(signed'(AW'(focus_pos)) + dist_s);
          vel_c  = (spd_mag == 0) ? 17'sd32768 : spd_mag;
          mode_c = MODE_TARGET;
        end else if (spd_q != 0) begin
          vel_c  = spd17;
          mode_c = MODE_CONT;
        end else begin
          vel_c  = '0;
          mode_c = MODE_IDLE;
        end
        if (mode_c == MODE_CONT &&
            !((vel_c > 0 && focus_pos < FULL) || (vel_c < 0 && focus_pos != '0))) begin
          vel_c  = '0;
          mode_c = MODE_IDLE;
        end
        if (mode_c == MODE_TARGET && tgt_c == focus_pos) begin
          vel_c  = '0;
          mode_c = MODE_IDLE;
        end
      end
      OP_STOP: begin
        vel_c  = '0;
        mode_c = MODE_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      full_rate <= FULL_RATE_RESET;
      focus_pos <= MID;
      mode      <= MODE_IDLE;
      vel       <= '0;
      target    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) full_rate <= cfg_data;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_WAIT: begin
          if (accept) begin
            op_q   <= s_tuser;
            dist_q <= s_tdata[32:16];
            spd_q  <= s_tdata[48:33];
            state  <= (mode == MODE_IDLE) ? ST_CMD : ST_STEP;
          end
        end
        ST_STEP: begin
          if (rsp.done) state <= ST_ADV;
        end
        ST_ADV: begin
          focus_pos <= adv_pos;
          if (adv_idle) begin
            mode <= MODE_IDLE;
            vel  <= '0;
          end
          state <= ST_CMD;
        end
        ST_CMD: begin
          if (load_out) begin
            mode     <= mode_c;
            vel      <= vel_c;
            target   <= tgt_c;
            m_tdata  <= {7'b0, mode_c != MODE_IDLE, 16'(focus_pos)};
            state    <= ST_WAIT;
          end
        end
        default: state <= ST_WAIT;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/facm_step_unit.sv]
// Step length unit: one shared multiplier used for three passes, the last a
// reciprocal multiply for the divide by 1000. Depends on facm_pkg for the structs and constants.
`default_nettype none

module facm_step_unit import facm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire step_req_t req,
  output step_rsp_t      rsp
);

  localparam int PW = 2 * DVD_W;

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL1 = 4'b0010,
    U_MUL2 = 4'b0100,
    U_MUL3 = 4'b1000
  } ustate_t;

  ustate_t           ustate;
  logic [DVD_W-1:0]  opa;
  logic [DVD_W-1:0]  opb;
  logic [15:0]       ms_q;
  logic [STEP_W-1:0] quo;

  logic [PW-1:0] prod;

  assign prod = PW'(opa) * PW'(opb);

  assign rsp.done = (ustate == U_MUL3);
  assign rsp.step = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
    end else begin
      case (ustate)
        U_IDLE: begin
          if (req.start) begin
            opa    <= DVD_W'(req.rate);
            opb    <= DVD_W'(req.mag);
            ms_q   <= req.ms;
            ustate <= U_MUL1;
          end
        end
        U_MUL1: begin
          opa    <= prod[DVD_W-1:0];
          opb    <= DVD_W'(ms_q);
          ustate <= U_MUL2;
        end
        U_MUL2: begin
          opa    <= prod[RATE_FRAC +: DVD_W];
          opb    <= MS_RECIP;
          ustate <= U_MUL3;
        end
        U_MUL3: begin
          quo    <= prod[MS_RECIP_SH +: STEP_W];
          ustate <= U_IDLE;
        end
        default: ustate <= U_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/facm_checker.sv]
// Port-level checks for focus_actuator_motion_model_core, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module facm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not empty and ready after reset");

endmodule

bind focus_actuator_motion_model_core facm_checker u_facm_checker (.*);

`default_nettype wire
